// ===== rtl/mec_pkg.sv =====
// ----------------------------------------------------------------------------
// mec_pkg
// shared types, register map and fixed-point helpers of the escape counter
// ----------------------------------------------------------------------------
package mec_pkg;

   // q4.28 fixed point
   localparam int Q_FRAC = 28;

   // |z|^2 escape bound, 4.0 in q8.56
   localparam logic [63:0] ESCAPE_BOUND = 64'h0400_0000_0000_0000;

   // register map
   localparam int CSR_ADDR_WIDTH = 5;
   localparam logic [2:0] REG_REAL_ORIGIN     = 3'd0;
   localparam logic [2:0] REG_IMAG_ORIGIN     = 3'd1;
   localparam logic [2:0] REG_REAL_STEP       = 3'd2;
   localparam logic [2:0] REG_IMAG_STEP       = 3'd3;
   localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd4;
   localparam logic [2:0] REG_ITERATION_LIMIT = 3'd5;

   // reset values
   localparam logic signed [31:0] RST_REAL_ORIGIN     = -32'sd536870912;
   localparam logic signed [31:0] RST_IMAG_ORIGIN     = -32'sd402653184;
   localparam logic [30:0]        RST_REAL_STEP       = 31'd196608;
   localparam logic [30:0]        RST_IMAG_STEP       = 31'd196608;
   localparam logic [12:0]        RST_IMAGE_HEIGHT    = 13'd4096;
   localparam logic [15:0]        RST_ITERATION_LIMIT = 16'd256;

   typedef struct packed {
      logic signed [31:0] real_origin;
      logic signed [31:0] imag_origin;
      logic [30:0]        real_step;
      logic [30:0]        imag_step;
      logic [12:0]        image_height;
      logic [15:0]        iteration_limit;
   } mec_cfg_type;

   // point c handed from front end to iteration unit
   typedef struct packed {
      logic signed [31:0] c_re;
      logic signed [31:0] c_im;
   } mec_point_type;

   // clamp a wide signed value to the q4.28 range
   function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/mandelbrot_escape_counter_unit.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter_unit
// path: the front end's capture, multiply and sum states, the two-entry queue,
//   a multiply and evaluate pass per iteration, then the result register
// throughput: set by the iteration loop, which takes a new point only when idle;
//   the front end takes a new pixel only in its idle state
// reset: registers take their documented defaults, queue and result empty
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter_unit #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel transactions
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [11:0]                        req_pixel_row,
   input  logic [11:0]                        req_pixel_col,
   // result transactions
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [15:0]                        rsp_escape_count,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mec_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   mec_pkg::mec_cfg_type   cfg_ff;
   logic [2:0]             reg_index;
   logic                   reg_write;

   // front end to queue
   logic                   fq_valid, fq_ready;
   mec_pkg::mec_point_type fq_data;
   // queue to iteration unit
   logic                   qi_valid, qi_ready;
   mec_pkg::mec_point_type qi_data;

   // ---------------------------------------------------------------
   // register file: written in the access phase, read combinationally
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign reg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.real_origin     <= mec_pkg::RST_REAL_ORIGIN;
         cfg_ff.imag_origin     <= mec_pkg::RST_IMAG_ORIGIN;
         cfg_ff.real_step       <= mec_pkg::RST_REAL_STEP;
         cfg_ff.imag_step       <= mec_pkg::RST_IMAG_STEP;
         cfg_ff.image_height    <= mec_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.iteration_limit <= mec_pkg::RST_ITERATION_LIMIT;
      end else if (reg_write) begin
         case (reg_index)
            mec_pkg::REG_REAL_ORIGIN:     cfg_ff.real_origin     <= pwdata;
            mec_pkg::REG_IMAG_ORIGIN:     cfg_ff.imag_origin     <= pwdata;
            mec_pkg::REG_REAL_STEP:       cfg_ff.real_step       <= pwdata[30:0];
            mec_pkg::REG_IMAG_STEP:       cfg_ff.imag_step       <= pwdata[30:0];
            mec_pkg::REG_IMAGE_HEIGHT:    cfg_ff.image_height    <= pwdata[12:0];
            mec_pkg::REG_ITERATION_LIMIT: cfg_ff.iteration_limit <= pwdata[15:0];
            default: begin
               // unmapped address, write ignored
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         mec_pkg::REG_REAL_ORIGIN:     prdata = cfg_ff.real_origin;
         mec_pkg::REG_IMAG_ORIGIN:     prdata = cfg_ff.imag_origin;
         mec_pkg::REG_REAL_STEP:       prdata = {1'b0, cfg_ff.real_step};
         mec_pkg::REG_IMAG_STEP:       prdata = {1'b0, cfg_ff.imag_step};
         mec_pkg::REG_IMAGE_HEIGHT:    prdata = {19'b0, cfg_ff.image_height};
         mec_pkg::REG_ITERATION_LIMIT: prdata = {16'b0, cfg_ff.iteration_limit};
         default:                      prdata = 32'b0;
      endcase
   end

   // ---------------------------------------------------------------
   // front end: row mirroring, column clamp, c = origin + index * step
   // ---------------------------------------------------------------
   mec_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_row (req_pixel_row),
      .req_pixel_col (req_pixel_col),
      .push_valid    (fq_valid),
      .push_ready    (fq_ready),
      .push_data     (fq_data)
   );

   // ---------------------------------------------------------------
   // short queue so the front end keeps taking pixels during a long loop
   // ---------------------------------------------------------------
   mec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qi_valid),
      .pop_ready  (qi_ready),
      .pop_data   (qi_data)
   );

   // ---------------------------------------------------------------
   // back end: escape loop and result register
   // ---------------------------------------------------------------
   mec_iter u_iter (
      .clock            (clock),
      .reset            (reset),
      .iteration_limit  (cfg_ff.iteration_limit),
      .pop_valid        (qi_valid),
      .pop_ready        (qi_ready),
      .pop_data         (qi_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escape_count (rsp_escape_count)
   );

endmodule

// ===== rtl/mec_front.sv =====
// ----------------------------------------------------------------------------
// mec_front
// takes pixel transactions, mirrors rows past the midline, clamps the column, forms c
// ----------------------------------------------------------------------------
module mec_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mec_pkg::mec_cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [11:0]            req_pixel_row,
   input  logic [11:0]            req_pixel_col,
   output logic                   push_valid,
   input  logic                   push_ready,
   output mec_pkg::mec_point_type push_data
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_SUM,
      F_PUSH
   } front_state_type;

   front_state_type        state_ff;
   logic [11:0]            row_ff, row_in;
   logic [11:0]            col_ff, col_in;
   logic [42:0]            prod_re_ff, prod_im_ff;
   mec_pkg::mec_point_type point_ff;
   logic [12:0]            h_eff;
   logic                   mirror;

   always_comb begin
      h_eff = (32'(cfg.image_height) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : cfg.image_height;
      mirror = ({1'b0, req_pixel_row} < h_eff) &&
               ({req_pixel_row, 1'b0} > (h_eff - 13'd1));
      row_in = mirror ? 12'(h_eff - 13'd1 - {1'b0, req_pixel_row}) : req_pixel_row;
      col_in = (32'(req_pixel_col) >= MAX_WIDTH) ? 12'(MAX_WIDTH - 1) : req_pixel_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  row_ff   <= row_in;
                  col_ff   <= col_in;
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               prod_re_ff <= 43'(col_ff) * 43'(cfg.real_step);
               prod_im_ff <= 43'(row_ff) * 43'(cfg.imag_step);
               state_ff   <= F_SUM;
            end
            F_SUM: begin
               point_ff.c_re <= mec_pkg::sat_q(64'(cfg.real_origin) +
                                               $signed({21'b0, prod_re_ff}));
               point_ff.c_im <= mec_pkg::sat_q(64'(cfg.imag_origin) +
                                               $signed({21'b0, prod_im_ff}));
               state_ff      <= F_PUSH;
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = point_ff;

endmodule

// ===== rtl/mec_queue.sv =====
// ----------------------------------------------------------------------------
// mec_queue
// two-entry queue of points between front end and iteration unit
// ----------------------------------------------------------------------------
module mec_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  mec_pkg::mec_point_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output mec_pkg::mec_point_type pop_data
);

   mec_pkg::mec_point_type entry_ff [2];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             fill_ff;
   logic                   do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

// ===== rtl/mec_iter.sv =====
// ----------------------------------------------------------------------------
// mec_iter
// escape-time loop: z = z^2 + c on three multipliers, result register
// ----------------------------------------------------------------------------
module mec_iter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [15:0]            iteration_limit,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  mec_pkg::mec_point_type pop_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_escape_count
);

   typedef enum logic [1:0] {
      I_IDLE,
      I_MUL,
      I_EVAL,
      I_DONE
   } iter_state_type;

   iter_state_type     state_ff;
   logic signed [31:0] c_re_ff, c_im_ff;
   logic signed [31:0] z_re_ff, z_im_ff;
   logic signed [63:0] rr_ff, ii_ff, ri_ff;
   logic [15:0]        count_ff;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_count_ff;

   logic [63:0]        mag;
   logic               escaped;
   logic signed [63:0] diff;
   logic signed [31:0] z_re_in, z_im_in;
   logic               more;
   logic               rsp_load;

   always_comb begin
      mag     = 64'(rr_ff) + 64'(ii_ff);
      escaped = (mag > mec_pkg::ESCAPE_BOUND);
      diff    = rr_ff - ii_ff;
      z_re_in = mec_pkg::sat_q((diff >>> mec_pkg::Q_FRAC) + 64'(c_re_ff));
      z_im_in = mec_pkg::sat_q((ri_ff >>> (mec_pkg::Q_FRAC - 1)) + 64'(c_im_ff));
      // another pass allowed once count has moved on by one
      more    = (({1'b0, count_ff} + 17'd2) < {1'b0, iteration_limit});
      // result register free or emptied this cycle
      rsp_load = (state_ff == I_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= I_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            I_IDLE: begin
               if (pop_valid) begin
                  c_re_ff  <= pop_data.c_re;
                  c_im_ff  <= pop_data.c_im;
                  z_re_ff  <= pop_data.c_re;
                  z_im_ff  <= pop_data.c_im;
                  count_ff <= 16'd0;
                  state_ff <= (iteration_limit > 16'd1) ? I_MUL : I_DONE;
               end
            end
            I_MUL: begin
               rr_ff    <= 64'(z_re_ff) * 64'(z_re_ff);
               ii_ff    <= 64'(z_im_ff) * 64'(z_im_ff);
               ri_ff    <= 64'(z_re_ff) * 64'(z_im_ff);
               state_ff <= I_EVAL;
            end
            I_EVAL: begin
               if (escaped) begin
                  state_ff <= I_DONE;
               end else begin
                  z_re_ff  <= z_re_in;
                  z_im_ff  <= z_im_in;
                  count_ff <= count_ff + 16'd1;
                  state_ff <= more ? I_MUL : I_DONE;
               end
            end
            I_DONE: begin
               if (rsp_load) begin
                  rsp_count_ff <= count_ff;
                  state_ff     <= I_IDLE;
               end
            end
            default: begin
               state_ff <= I_IDLE;
            end
         endcase
      end
   end

   assign pop_ready        = (state_ff == I_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;

endmodule
